[hdl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the size-aware lfu cache directory.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned EntriesDefault = 64;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned StampW = 48;
  localparam int unsigned EvictW = 7;
  localparam logic [SizeW-1:0]  CapacityReset = '1;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [EvictW-1:0] EvictMax = '1;
  localparam logic [CountW-1:0] CountInit = CountW'(1);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_SCAN,
    ST_EVICT,
    ST_INSERT
  } lfu_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic scan_start; // clear the scan pointer and best trackers
    logic scan_step;  // examine one slot
    logic do_hit;     // update the hit entry
    logic do_evict;   // drop the chosen victim
    logic do_insert;  // write the new entry into the free slot
    logic do_tick;    // advance the access clock
    logic load_out;   // load the result register
    logic res_too_big;
  } lfu_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;  // current slot is the last one
    logic hit_found;
    logic too_big;
    logic fits;
    logic free_found;
    logic victim_found;
  } lfu_status_t;

endpackage

[hdl/lfu_ram.sv]
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-port-write, single-port-read ram with registered read.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/lfu_datapath.sv]
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry store, scan pointer, victim tracking and occupancy for the lfu cache.
// ----------------------------------------------------------------------------
module lfu_datapath #(
  parameter int unsigned Entries = lfu_pkg::EntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfu_pkg::lfu_cmd_t              cmd_i,
  output lfu_pkg::lfu_status_t           status_o,
  input  logic [lfu_pkg::SizeW-1:0]      capacity_i,
  input  logic [lfu_pkg::KeyW-1:0]       key_i,
  input  logic [lfu_pkg::SizeW-1:0]      object_size_i,
  output logic                           hit_o,
  output logic                           too_big_o,
  output logic [lfu_pkg::EvictW-1:0]     evicted_count_o,
  output logic [lfu_pkg::SizeW-1:0]      used_units_o
);
  import lfu_pkg::*;

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned RecW = KeyW + SizeW + CountW + StampW;

  // latched item
  logic [KeyW-1:0]  key_q;
  logic [SizeW-1:0] size_q;

  // valid bits, one flip-flop per slot
  logic [Entries-1:0] valid_q, valid_d;

  // scan pointer: ptr_q is the address presented, chk_q the slot whose data returns
  logic [IdxW-1:0] ptr_q, chk_q;
  logic            chk_v_q;

  logic            hit_found_q, free_found_q, victim_found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, victim_idx_q;
  logic [CountW-1:0] hit_cnt_q, best_cnt_q;
  logic [SizeW-1:0]  hit_size_q;
  logic [StampW-1:0] best_stamp_q;
  logic [SizeW-1:0]  victim_size_q;

  logic [StampW-1:0] clock_q;
  logic [SizeW-1:0]  occ_q;
  logic [EvictW-1:0] evict_q;

  logic              out_hit_q, out_tb_q;
  logic [EvictW-1:0] out_ev_q;
  logic [SizeW-1:0]  out_used_q;

  // ram ports
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [RecW-1:0] wdata, rdata;
  logic [KeyW-1:0]   rd_key;
  logic [SizeW-1:0]  rd_size;
  logic [CountW-1:0] rd_cnt;
  logic [StampW-1:0] rd_stamp;
  logic              chk_valid, better;

  assign {rd_key, rd_size, rd_cnt, rd_stamp} = rdata;
  assign chk_valid = chk_v_q && valid_q[chk_q];
  assign better = !victim_found_q || (rd_cnt < best_cnt_q) ||
                  ((rd_cnt == best_cnt_q) && (rd_stamp < best_stamp_q));

  // write mux: hit update keeps the stored size, insert takes the new one
  always_comb begin
    we    = 1'b0;
    waddr = free_idx_q;
    wdata = {key_q, size_q, CountInit, clock_q};
    if (cmd_i.do_hit) begin
      we    = 1'b1;
      waddr = hit_idx_q;
      wdata = {key_q, hit_size_q,
               (hit_cnt_q == CountMax) ? hit_cnt_q : hit_cnt_q + CountW'(1), clock_q};
    end else if (cmd_i.do_insert && free_found_q) begin
      we = 1'b1;
    end
  end

  lfu_ram #(.Width(RecW), .Depth(Entries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q  <= key_i;
      size_q <= object_size_i;
    end
  end

  // valid bits
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.do_evict) valid_d[victim_idx_q] = 1'b0;
    if (cmd_i.do_insert && free_found_q) valid_d[free_idx_q] = 1'b1;
  end

  // scan and tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      ptr_q          <= '0;
      chk_q          <= '0;
      chk_v_q        <= 1'b0;
      hit_found_q    <= 1'b0;
      free_found_q   <= 1'b0;
      victim_found_q <= 1'b0;
      hit_idx_q      <= '0;
      free_idx_q     <= '0;
      victim_idx_q   <= '0;
      hit_cnt_q      <= '0;
      hit_size_q     <= '0;
      best_cnt_q     <= '0;
      best_stamp_q   <= '0;
      victim_size_q  <= '0;
      clock_q        <= '0;
      occ_q          <= '0;
      evict_q        <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.capture) evict_q <= '0;
      if (cmd_i.scan_start) begin
        ptr_q          <= '0;
        chk_v_q        <= 1'b0;
        hit_found_q    <= 1'b0;
        free_found_q   <= 1'b0;
        victim_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        ptr_q   <= (ptr_q == IdxW'(Entries - 1)) ? ptr_q : ptr_q + IdxW'(1);
        chk_q   <= ptr_q;
        chk_v_q <= 1'b1;
        if (chk_v_q) begin
          if (chk_valid && !hit_found_q && rd_key == key_q) begin
            hit_found_q <= 1'b1;
            hit_idx_q   <= chk_q;
            hit_cnt_q   <= rd_cnt;
            hit_size_q  <= rd_size;
          end
          if (!valid_q[chk_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= chk_q;
          end
          if (chk_valid && better) begin
            victim_found_q <= 1'b1;
            victim_idx_q   <= chk_q;
            best_cnt_q     <= rd_cnt;
            best_stamp_q   <= rd_stamp;
            victim_size_q  <= rd_size;
          end
        end
      end
      if (cmd_i.do_evict) begin
        occ_q   <= occ_q - victim_size_q;
        evict_q <= (evict_q == EvictMax) ? evict_q : evict_q + EvictW'(1);
      end
      if (cmd_i.do_insert && free_found_q) occ_q <= occ_q + size_q;
      if (cmd_i.do_tick) clock_q <= clock_q + StampW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q  <= cmd_i.do_hit;
      out_tb_q   <= cmd_i.res_too_big;
      out_ev_q   <= (cmd_i.do_hit || cmd_i.res_too_big) ? '0 : evict_q;
      out_used_q <= (cmd_i.do_insert && free_found_q) ? occ_q + size_q : occ_q;
    end
  end

  assign hit_o           = out_hit_q;
  assign too_big_o       = out_tb_q;
  assign evicted_count_o = out_ev_q;
  assign used_units_o    = out_used_q;

  assign status_o.scan_last    = chk_v_q && (chk_q == IdxW'(Entries - 1));
  assign status_o.hit_found    = hit_found_q;
  assign status_o.too_big      = (size_q >= capacity_i);
  assign status_o.fits         = ({1'b0, occ_q} + {1'b0, size_q}) < {1'b0, capacity_i};
  assign status_o.free_found   = free_found_q;
  assign status_o.victim_found = victim_found_q;

  // checks
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_evict |-> valid_q[victim_idx_q]) else $error("evicting an empty slot");
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_insert && free_found_q) |-> !valid_q[free_idx_q])
    else $error("insert into an occupied slot");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.do_hit && cmd_i.do_insert)) else $error("hit and insert together");

endmodule

[hdl/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for lookup, eviction scans, insert and result handoff.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  lfu_pkg::lfu_status_t status_i,
  output lfu_pkg::lfu_cmd_t    cmd_o
);
  import lfu_pkg::*;

  lfu_state_e state_q, state_d;
  logic       out_v_q;
  logic       accept, out_free;

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: if (status_i.scan_last) state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.hit_found || status_i.too_big) begin
          if (out_free) state_d = ST_IDLE;
        end else if (status_i.fits && status_i.free_found) begin
          state_d = ST_INSERT;
        end else if (status_i.victim_found) begin
          state_d = ST_EVICT;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_EVICT:  state_d = ST_SCAN;
      ST_SCAN:   if (status_i.scan_last) state_d = ST_CHECK;
      ST_INSERT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture    = accept;
        cmd_o.scan_start = accept;
      end
      ST_LOOKUP, ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_CHECK: begin
        if (status_i.hit_found) begin
          cmd_o.do_hit   = out_free;
          cmd_o.do_tick  = out_free;
          cmd_o.load_out = out_free;
        end else if (status_i.too_big) begin
          cmd_o.res_too_big = 1'b1;
          cmd_o.load_out    = out_free;
        end
      end
      ST_EVICT: begin
        cmd_o.do_evict   = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      ST_INSERT: begin
        cmd_o.do_insert = out_free;
        cmd_o.do_tick   = out_free;
        cmd_o.load_out  = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free) else $error("result overwritten");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOKUP) else $error("accept did not start lookup");
  a_evict_rescan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_evict |=> state_q == ST_SCAN) else $error("evict not followed by scan");

endmodule

[hdl/lfu_size_aware_cache.sv]
// ----------------------------------------------------------------------------
// lfu_size_aware_cache
// Size-aware least-frequently-used cache directory.
// ----------------------------------------------------------------------------
// Usage: each input item carries key_i and object_size_i and is taken when
// in_valid_i is high and in_stall_o low. One result item (hit_o, too_big_o,
// evicted_count_o, used_units_o) follows per input item on out_valid_o and
// is held while out_stall_i is high. capacity_units sits at apb address 0.
// Flow: a lookup pass walks all ENTRIES slots through the entry ram, one
// a cycle, then a decision state follows. A hit or rejected item has its
// result loaded in the decision state and the next item is then taken in
// the idle state. Each eviction adds an evict state, a rescan of all slots
// and another decision state, and a miss ends with an insert state. One
// item is in work at a time; the next is accepted once the result is
// loaded.
// Reset clears the valid bits, occupancy and access clock and sets the
// capacity to all ones. A stalled result holds the block in its final state
// until the receiver takes the previous result.
// ----------------------------------------------------------------------------
module lfu_size_aware_cache #(
  parameter int unsigned ENTRIES = lfu_pkg::EntriesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lfu_pkg::KeyW-1:0]   key_i,
  input  logic [lfu_pkg::SizeW-1:0]  object_size_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic                       too_big_o,
  output logic [lfu_pkg::EvictW-1:0] evicted_count_o,
  output logic [lfu_pkg::SizeW-1:0]  used_units_o
);
  import lfu_pkg::*;

  localparam logic [1:0] AddrCapacity = 2'd0;

  logic [SizeW-1:0] capacity_q;
  lfu_cmd_t         cmd;
  lfu_status_t      status;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (psel && penable && pwrite && paddr == AddrCapacity) begin
      capacity_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrCapacity) ? capacity_q : '0;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfu_datapath #(.Entries(ENTRIES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .capacity_i      (capacity_q),
    .key_i           (key_i),
    .object_size_i   (object_size_i),
    .hit_o           (hit_o),
    .too_big_o       (too_big_o),
    .evicted_count_o (evicted_count_o),
    .used_units_o    (used_units_o)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-aware lfu cache directory: directed and
// random accesses across several capacity settings, each result compared
// against a cycle-free model of the directory kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import lfu_pkg::*;

  localparam int unsigned Slots = 64;
  localparam logic [1:0] AddrCapacity = 2'd0;
  localparam int unsigned IdleLimit = 40000;
  localparam logic [StampW-1:0] StampMask = '1;

  typedef struct packed {
    logic              hit;
    logic              too_big;
    logic [EvictW-1:0] evicted;
    logic [SizeW-1:0]  used;
  } access_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KeyW-1:0] key_i = '0;
  logic [SizeW-1:0] object_size_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o, too_big_o;
  logic [EvictW-1:0] evicted_count_o;
  logic [SizeW-1:0] used_units_o;

  lfu_size_aware_cache #(.ENTRIES(Slots)) u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .key_i, .object_size_i,
    .out_valid_o, .out_stall_i, .hit_o, .too_big_o, .evicted_count_o, .used_units_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the directory
  logic              dir_valid [Slots];
  logic [KeyW-1:0]   dir_key   [Slots];
  logic [SizeW-1:0]  dir_size  [Slots];
  logic [CountW-1:0] dir_count [Slots];
  logic [StampW-1:0] dir_stamp [Slots];
  logic [StampW-1:0] mdl_clock;
  logic [SizeW-1:0]  mdl_used;
  logic [SizeW-1:0]  mdl_capacity;

  access_res_t expected_q[$];
  int err_count = 0;
  int sent_count = 0;
  int got_count = 0;
  int hit_seen = 0, evict_seen = 0, big_seen = 0;
  bit calm = 1'b0;
  int idle_cycles = 0;
  logic [KeyW-1:0] key_pool[$];

  function automatic int find_victim();
    int best = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!dir_valid[i]) continue;
      if (best < 0 || dir_count[i] < dir_count[best] ||
          (dir_count[i] == dir_count[best] && dir_stamp[i] < dir_stamp[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < Slots; i++)
      if (!dir_valid[i]) return i;
    return -1;
  endfunction

  // work out the result of one access and update the model
  function automatic access_res_t predict_access(logic [KeyW-1:0] k, logic [SizeW-1:0] sz);
    access_res_t r;
    int slot = -1;
    int v, f;
    r = '0;
    for (int i = 0; i < Slots; i++)
      if (dir_valid[i] && dir_key[i] == k) begin
        slot = i;
        break;
      end
    if (slot >= 0) begin
      r.hit = 1'b1;
      if (dir_count[slot] != CountMax) dir_count[slot]++;
      dir_stamp[slot] = mdl_clock;
      mdl_clock = (mdl_clock + 1) & StampMask;
    end else if (sz >= mdl_capacity) begin
      r.too_big = 1'b1;
    end else begin
      forever begin
        if ({32'd0, mdl_used} + {32'd0, sz} < {32'd0, mdl_capacity} && find_free() >= 0)
          break;
        v = find_victim();
        if (v < 0) break;
        dir_valid[v] = 1'b0;
        mdl_used -= dir_size[v];
        if (r.evicted != EvictMax) r.evicted++;
      end
      f = find_free();
      if (f >= 0) begin
        dir_valid[f] = 1'b1;
        dir_key[f] = k;
        dir_size[f] = sz;
        dir_count[f] = CountInit;
        dir_stamp[f] = mdl_clock;
        mdl_used += sz;
      end
      mdl_clock = (mdl_clock + 1) & StampMask;
    end
    r.used = mdl_used;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on item %0d: %s got %0h expected %0h", got_count, what, got, want);
    err_count++;
  endtask

  // random output stalls with calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 22);
  end

  // result checker
  always @(posedge clk_i) begin
    access_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result item with nothing pending");
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (too_big_o !== want.too_big) report_mismatch("too_big", too_big_o, want.too_big);
        if (evicted_count_o !== want.evicted)
          report_mismatch("evicted_count", evicted_count_o, want.evicted);
        if (used_units_o !== want.used) report_mismatch("used_units", used_units_o, want.used);
        if (want.hit) hit_seen++;
        if (want.evicted != 0) evict_seen++;
        if (want.too_big) big_seen++;
      end
      got_count++;
    end
  end

  // watchdog on accepted items
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays high from one item straight into the next; it drops only when idling
  task automatic send_access(logic [KeyW-1:0] k, logic [SizeW-1:0] sz);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (!calm && $urandom_range(99) < 22) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i <= k;
    object_size_i <= sz;
    expected_q.push_back(predict_access(k, sz));
    sent_count++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3 * Slots) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [31:0] val);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrCapacity; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_capacity = val;
    @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(99) < 35) begin
      key_pool.push_back(rand_key() & 64'h0000_0000_0000_00FF | {$urandom(), 32'd0});
      if (key_pool.size() > 120) void'(key_pool.pop_front());
      return key_pool[$];
    end
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // extremes of key and size, hits and rejects at default capacity
  task automatic test_directed();
    send_access('0, '0);
    send_access('1, 32'd5);
    send_access('0, '1);
    send_access('1, 32'd7);
    send_access(64'hA5A5_5A5A_F0F0_0F0F, 32'hFFFF_FFFE);
    send_access(64'h5A5A_A5A5_0F0F_F0F0, 32'd10);
    send_access(64'h5A5A_A5A5_0F0F_F0F0, '1);
    send_access(64'h1234, '1);
    for (int i = 0; i < 8; i++) send_access(64'h100 + i, 32'd1);
  endtask

  // fill past the slot count so the full table path evicts
  task automatic test_full_table();
    for (int i = 0; i < 70; i++) send_access(64'h2000 + i, '0);
  endtask

  // small capacity with lowered budget and zero capacity rejects
  task automatic test_small_capacity();
    write_capacity(32'd1);
    send_access(64'h3000, '0);
    send_access(64'h3001, 32'd1);
    write_capacity(32'd50);
    for (int i = 0; i < 12; i++) send_access(64'h3100 + i, 32'd9);
    write_capacity(32'd20);
    send_access(64'h3200, 32'd3);
    write_capacity(32'd0);
    send_access(64'h3300, 32'd0);
  endtask

  task automatic test_random(int n, logic [31:0] cap, int max_size);
    logic [SizeW-1:0] sz;
    write_capacity(cap);
    for (int i = 0; i < n; i++) begin
      calm = (i % 160) >= 120;
      case ($urandom_range(9))
        0: sz = {$urandom()};
        1: sz = '0;
        default: sz = $urandom_range(max_size);
      endcase
      if ($urandom_range(99) < 8) send_access(rand_key(), sz);
      else send_access(pick_key(), sz);
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      dir_valid[i] = 1'b0; dir_key[i] = '0; dir_size[i] = '0;
      dir_count[i] = '0; dir_stamp[i] = '0;
    end
    mdl_clock = '0;
    mdl_used = '0;
    mdl_capacity = CapacityReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_small_capacity();
    test_random(250, 32'd400, 60);
    test_random(250, 32'd2000, 300);
    test_random(150, 32'hFFFF_FFFF, 1000);
    test_random(150, 32'd100, 40);
    drain();
    $display("covered %0d items: %0d hits, %0d evicting misses, %0d rejects",
             sent_count, hit_seen, evict_seen, big_seen);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
